@@ hdl/kms_pkg.sv @@
package kms_pkg;

	// Fixed field widths
	localparam int ROW_W = 8;
	localparam int KEY_W = 6;
	localparam int DRV_W = 3;
	localparam int CFG_W = 4;
	localparam int RIDX_W = 3;

	// Configuration register indexes
	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	// Reset values of the configuration registers
	localparam logic [CFG_W-1:0] NUM_ROWS_RST = 4'd8;
	localparam logic [CFG_W-1:0] NUM_COLS_RST = 4'd8;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_EMIT
	} state_t;

endpackage

@@ hdl/kms_ram.sv @@
module kms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/key_matrix_scanner_top.sv @@
// Key matrix scanner.
// Input channel (in_valid/in_stall, row_levels): one transaction per column
// sample, holding the row levels seen while the current column is driven.
// Output channel (out_valid/out_stall): one transaction per changed key of
// that sample, in ascending row order, with key_index, pressed and last;
// a sample with no change gives one transaction with event_valid low.
// Every output transaction carries drive_column/drive_enable, the column to
// drive for the next sample (drive_enable low when num_cols is zero).
// Configuration: cfg_we, cfg_index and cfg_data write num_rows (index 0)
// or num_cols (index 1); write only while the block is idle.
// Timing: an item is taken, the column's stored levels are read from the
// key RAM, compared and written back, then one result leaves per cycle
// while the output is not stalled. One item is in work at a time; in_stall
// is high from acceptance until its final result is in the output register.
// Reset clears the column pointer, the registers to eight rows and eight
// columns, and the per-column valid flags, so every key reads as released.
// A stalled output holds its result; the sequencer waits behind it.
module key_matrix_scanner_top #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [kms_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [kms_pkg::ROW_W-1:0]   row_levels,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [kms_pkg::DRV_W-1:0]   drive_column,
	output logic                        drive_enable,
	output logic                        event_valid,
	output logic [kms_pkg::KEY_W-1:0]   key_index,
	output logic                        pressed,
	output logic                        last
);

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_LIM = (MAX_ROWS < kms_pkg::ROW_W) ? MAX_ROWS : kms_pkg::ROW_W;
	localparam int ROW_W = kms_pkg::ROW_W;
	localparam int CFG_W = kms_pkg::CFG_W;
	localparam int DRV_W = kms_pkg::DRV_W;
	localparam int KEY_W_T = kms_pkg::KEY_W;

	kms_pkg::state_t state_q, state_d;

	logic [CFG_W-1:0] num_rows_q, num_cols_q;
	logic [COL_W-1:0] cur_col_q;
	logic [MAX_COLS-1:0] col_valid_q;

	logic [CFG_W-1:0] rows_eff;
	logic [CFG_W:0]   cols_eff;
	logic [COL_W-1:0] col_sel, next_col;
	logic [CFG_W:0]   next_ext;
	logic             en_sel;

	logic [ROW_W-1:0] levels_s1, mask_s1;
	logic [COL_W-1:0] col_s1;
	logic [CFG_W-1:0] rows_s1;

	logic [ROW_W-1:0] diff_q;
	logic [7:0]       base_q;
	logic [DRV_W-1:0] drv_col_q;
	logic             drv_en_q;

	logic [ROW_W-1:0] rd_data, stored, new_store, mask_d;
	logic [kms_pkg::RIDX_W-1:0] r_idx;
	logic             is_last;
	logic             accept, out_free, emit;

	// Effective register values
	always_comb begin
		rows_eff = ({1'b0, num_rows_q} > 5'(ROW_LIM)) ? CFG_W'(ROW_LIM) : num_rows_q;
		cols_eff = ({1'b0, num_cols_q} > 5'(MAX_COLS)) ? 5'(MAX_COLS) : {1'b0, num_cols_q};
	end

	// Pick the column to sample and the one after it
	always_comb begin
		if (cols_eff == '0) begin
			col_sel = '0;
			en_sel  = 1'b0;
		end else begin
			col_sel = (5'(cur_col_q) < cols_eff) ? cur_col_q : '0;
			en_sel  = 1'b1;
		end
		next_ext = 5'(col_sel) + 5'd1;
		next_col = (next_ext >= cols_eff) ? '0 : COL_W'(next_ext);
	end

	// Row-in-use mask
	always_comb begin
		for (int r = 0; r < ROW_W; r++) begin
			mask_d[r] = (4'(r) < rows_eff);
		end
	end

	// Key level store
	kms_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_COLS)
	) u_ram (
		.clk   (clk),
		.we    (state_q == kms_pkg::S_LOAD),
		.waddr (col_s1),
		.wdata (new_store),
		.re    (accept),
		.raddr (col_sel),
		.rdata (rd_data)
	);

	// Compare with stored levels; unwritten columns read as released
	always_comb begin
		stored    = col_valid_q[col_s1] ? rd_data : '0;
		new_store = (stored & ~mask_s1) | (levels_s1 & mask_s1);
	end

	// Lowest pending change and whether it is the final one
	always_comb begin
		r_idx = '0;
		for (int r = ROW_W - 1; r >= 0; r--) begin
			if (diff_q[r]) begin
				r_idx = kms_pkg::RIDX_W'(r);
			end
		end
		is_last = ((diff_q & (diff_q - 1'b1)) == '0);
	end

	assign out_free = !out_valid || !out_stall;

	// Sequencer next state
	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		emit     = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			kms_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = kms_pkg::S_LOAD;
				end
			end
			kms_pkg::S_LOAD: begin
				state_d = kms_pkg::S_EMIT;
			end
			kms_pkg::S_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					if (is_last) begin
						state_d = kms_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = kms_pkg::S_IDLE;
			end
		endcase
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kms_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= kms_pkg::NUM_ROWS_RST;
			num_cols_q <= kms_pkg::NUM_COLS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kms_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data;
				kms_pkg::REG_NUM_COLS: num_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Column pointer and per-column valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= '0;
			col_valid_q <= '0;
		end else begin
			if (accept) begin
				cur_col_q <= next_col;
			end
			if (state_q == kms_pkg::S_LOAD) begin
				col_valid_q[col_s1] <= 1'b1;
			end
		end
	end

	// Capture the transaction and its column context
	always_ff @(posedge clk) begin
		if (accept) begin
			levels_s1 <= row_levels;
			mask_s1   <= mask_d;
			col_s1    <= col_sel;
			rows_s1   <= rows_eff;
			drv_col_q <= DRV_W'(next_col);
			drv_en_q  <= en_sel;
		end
	end

	// Load the change set, then drop each change as it is sent
	always_ff @(posedge clk) begin
		if (state_q == kms_pkg::S_LOAD) begin
			diff_q <= (levels_s1 ^ stored) & mask_s1;
			base_q <= 8'(col_s1) * 8'(rows_s1);
		end else if (emit) begin
			diff_q[r_idx] <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			drive_column <= drv_col_q;
			drive_enable <= drv_en_q;
			event_valid  <= (diff_q != '0);
			key_index    <= (diff_q != '0) ? KEY_W_T'(base_q + 8'(r_idx)) : '0;
			pressed      <= (diff_q != '0) ? levels_s1[r_idx] : 1'b0;
			last         <= is_last;
		end
	end

`ifndef SYNTHESIS
	// An accepted sample blocks the input until its results are out
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a sample is in work");

	// A sample without changes is reported by a single final transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !event_valid) |-> last)
		else $error("no-change result not marked last");

	// An undriven scan always points at column zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !drive_enable) |-> (drive_column == '0))
		else $error("undriven scan with non-zero column");

	// The compare cycle always hands over to result delivery
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kms_pkg::S_LOAD) |=> (state_q == kms_pkg::S_EMIT))
		else $error("compare cycle not followed by delivery");
`endif

endmodule
